>>> rtl/pft_pkg.sv
`timescale 1ns / 1ps
package pft_pkg;

  // Coordinate and register widths
  localparam int COORD_W    = 32;
  localparam int HEADING_W  = 16;
  localparam int CFG_IDX_W  = 2;

  // Operation codes carried with each item
  localparam logic OP_MAP_TO_VEHICLE = 1'b0;
  localparam logic OP_VEHICLE_TO_MAP = 1'b1;

  // Default width of the sine and cosine values, Q2.(TRIG_BITS-2)
  localparam int TRIG_BITS_DEF = 18;

  // Rotation unit: 2^32 angle units per turn, 2^30 is 1.0 for x and y
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_STEP_W = 5;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_FRAC  = 30;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POSE_X  = 2'd0,
    REG_POSE_Y  = 2'd1,
    REG_HEADING = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CORDIC_IDLE,
    CORDIC_ROTATE,
    CORDIC_FINISH
  } cordic_state_t;

  // arctan(2^-i) at 2^32 units per turn
  function automatic logic [CORDIC_W-1:0] cordic_atan(input logic [CORDIC_STEP_W-1:0] i);
    logic [CORDIC_W-1:0] a;
    unique case (i)
      5'd0:  a = 34'd536870912;
      5'd1:  a = 34'd316933406;
      5'd2:  a = 34'd167458907;
      5'd3:  a = 34'd85004756;
      5'd4:  a = 34'd42667331;
      5'd5:  a = 34'd21354465;
      5'd6:  a = 34'd10679838;
      5'd7:  a = 34'd5340245;
      5'd8:  a = 34'd2670163;
      5'd9:  a = 34'd1335087;
      5'd10: a = 34'd667544;
      5'd11: a = 34'd333772;
      5'd12: a = 34'd166886;
      5'd13: a = 34'd83443;
      5'd14: a = 34'd41722;
      5'd15: a = 34'd20861;
      5'd16: a = 34'd10430;
      5'd17: a = 34'd5215;
      5'd18: a = 34'd2608;
      5'd19: a = 34'd1304;
      5'd20: a = 34'd652;
      5'd21: a = 34'd326;
      5'd22: a = 34'd163;
      5'd23: a = 34'd81;
      5'd24: a = 34'd41;
      5'd25: a = 34'd20;
      5'd26: a = 34'd10;
      5'd27: a = 34'd5;
      5'd28: a = 34'd3;
      5'd29: a = 34'd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/pft_cordic.sv
`timescale 1ns / 1ps
module pft_cordic #(
  parameter int TRIG_BITS = pft_pkg::TRIG_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [pft_pkg::HEADING_W-1:0]       angle,
  output logic signed [TRIG_BITS-1:0]         cos_val,
  output logic signed [TRIG_BITS-1:0]         sin_val,
  output logic                                busy
);
  import pft_pkg::*;

  localparam int RND_SHIFT = CORDIC_FRAC - (TRIG_BITS - 2);
  localparam int EXT_W     = CORDIC_W + 1;
  localparam logic signed [EXT_W-1:0] HALF    = EXT_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [EXT_W-1:0] ONE_EXT = EXT_W'(1) <<< (TRIG_BITS - 2);

  cordic_state_t state, state_next;

  logic signed [CORDIC_W-1:0] x, y, z;
  logic [CORDIC_STEP_W-1:0]   step;
  logic [1:0]                 quadrant;
  logic                       do_load, do_rotate, do_finish;

  logic signed [CORDIC_W-1:0] dx, dy;
  logic signed [EXT_W-1:0]    xr, yr, xc, yc;
  logic signed [TRIG_BITS-1:0] c_fin, s_fin;

  always_comb begin
    state_next = state;
    unique case (state)
      CORDIC_IDLE:   if (start) state_next = CORDIC_ROTATE;
      CORDIC_ROTATE: if (step == CORDIC_STEP_W'(CORDIC_STEPS - 1)) state_next = CORDIC_FINISH;
      CORDIC_FINISH: state_next = CORDIC_IDLE;
      default:       state_next = CORDIC_IDLE;
    endcase
  end

  always_comb begin
    do_load   = 1'b0;
    do_rotate = 1'b0;
    do_finish = 1'b0;
    busy      = 1'b1;
    unique case (state)
      CORDIC_IDLE: begin
        busy    = 1'b0;
        do_load = start;
      end
      CORDIC_ROTATE: do_rotate = 1'b1;
      CORDIC_FINISH: do_finish = 1'b1;
      default:       busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= CORDIC_IDLE;
    else     state <= state_next;
  end

  // one micro-rotation a cycle
  assign dx = y >>> step;
  assign dy = x >>> step;

  always_ff @(posedge clk) begin
    if (do_load) begin
      x        <= CORDIC_GAIN;
      y        <= '0;
      z        <= CORDIC_W'({angle[HEADING_W-3:0], 16'd0});
      quadrant <= angle[HEADING_W-1 -: 2];
      step     <= '0;
    end else if (do_rotate) begin
      if (!z[CORDIC_W-1]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - $signed(cordic_atan(step));
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + $signed(cordic_atan(step));
      end
      step <= step + 1'b1;
    end
  end

  // round half up, clamp to +-1.0, then fold in the quadrant
  always_comb begin
    xr = (EXT_W'(x) + HALF) >>> RND_SHIFT;
    yr = (EXT_W'(y) + HALF) >>> RND_SHIFT;
    xc = (xr > ONE_EXT) ? ONE_EXT : ((xr < -ONE_EXT) ? -ONE_EXT : xr);
    yc = (yr > ONE_EXT) ? ONE_EXT : ((yr < -ONE_EXT) ? -ONE_EXT : yr);
    unique case (quadrant)
      2'd0: begin c_fin = TRIG_BITS'(xc);  s_fin = TRIG_BITS'(yc);  end
      2'd1: begin c_fin = -TRIG_BITS'(yc); s_fin = TRIG_BITS'(xc);  end
      2'd2: begin c_fin = -TRIG_BITS'(xc); s_fin = -TRIG_BITS'(yc); end
      default: begin c_fin = TRIG_BITS'(yc); s_fin = -TRIG_BITS'(xc); end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_val <= TRIG_BITS'(ONE_EXT);
      sin_val <= '0;
    end else if (do_finish) begin
      cos_val <= c_fin;
      sin_val <= s_fin;
    end
  end

endmodule

>>> rtl/planar_frame_transform_top.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// -------   -----------------------   ------------------------------------------
// command   start, busy (accept when  operation, point_x, point_y
//           start && !busy)
// result    done (one-cycle strobe)   out_x, out_y, saturated
// config    cfg_valid, cfg_ready      cfg_index, cfg_data
//
// One item per cycle while busy is low; results leave in order through the operand,
// product, combine and round stages. A heading write runs a 30-step shared CORDIC;
// busy and !cfg_ready hold while it runs. Pose writes take effect at once.
// Synchronous reset: pose 0, heading 0 (cosine 1.0, sine 0), pipeline empty.
// The result side cannot stall; every result is shown for exactly one cycle.
module planar_frame_transform_top #(
  parameter int TRIG_BITS = pft_pkg::TRIG_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 operation,
  input  logic signed [pft_pkg::COORD_W-1:0]   point_x,
  input  logic signed [pft_pkg::COORD_W-1:0]   point_y,
  output logic                                 done,
  output logic signed [pft_pkg::COORD_W-1:0]   out_x,
  output logic signed [pft_pkg::COORD_W-1:0]   out_y,
  output logic                                 saturated,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pft_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pft_pkg::COORD_W-1:0]          cfg_data
);
  import pft_pkg::*;

  // Operands carry one extra bit so point minus pose never wraps
  localparam int OPD_W   = COORD_W + 1;
  localparam int PROD_W  = OPD_W + TRIG_BITS;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RND_W   = SUM_W + 1;
  localparam int FIN_W   = RND_W + 1;
  localparam int T_SHIFT = TRIG_BITS - 2;
  localparam logic signed [RND_W-1:0] HALF = RND_W'(1) <<< (T_SHIFT - 1);
  localparam logic signed [FIN_W-1:0] SAT_MAX = FIN_W'(2147483647);
  localparam logic signed [FIN_W-1:0] SAT_MIN = -FIN_W'(64'sd2147483648);

  logic signed [COORD_W-1:0]   pose_x, pose_y;
  logic signed [TRIG_BITS-1:0] cos_val, sin_val;
  logic                        cordic_busy;
  logic                        cfg_wr, accept;

  assign cfg_ready = !cordic_busy;
  assign busy      = cordic_busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = start && !busy;

  // ---- configuration --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0;
      pose_y <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == REG_POSE_X) pose_x <= $signed(cfg_data);
      if (cfg_index == REG_POSE_Y) pose_y <= $signed(cfg_data);
    end
  end

  pft_cordic #(
    .TRIG_BITS (TRIG_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_wr && (cfg_index == REG_HEADING)),
    .angle   (cfg_data[HEADING_W-1:0]),
    .cos_val (cos_val),
    .sin_val (sin_val),
    .busy    (cordic_busy)
  );

  // ---- pipeline valid chain -------------------------------------------------
  logic v1, v2, v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // ---- stage 1: operands ----------------------------------------------------
  // Map to vehicle takes the difference from the pose first.
  logic                    op1;
  logic signed [OPD_W-1:0] a1, b1;

  always_ff @(posedge clk) begin
    if (accept) begin
      op1 <= operation;
      if (operation == OP_MAP_TO_VEHICLE) begin
        a1 <= OPD_W'(point_x) - OPD_W'(pose_x);
        b1 <= OPD_W'(point_y) - OPD_W'(pose_y);
      end else begin
        a1 <= OPD_W'(point_x);
        b1 <= OPD_W'(point_y);
      end
    end
  end

  // ---- stage 2: the four products ------------------------------------------
  logic                     op2;
  logic signed [PROD_W-1:0] p_ac, p_bs, p_bc, p_as;

  always_ff @(posedge clk) begin
    op2  <= op1;
    p_ac <= PROD_W'(a1) * PROD_W'(cos_val);
    p_bs <= PROD_W'(b1) * PROD_W'(sin_val);
    p_bc <= PROD_W'(b1) * PROD_W'(cos_val);
    p_as <= PROD_W'(a1) * PROD_W'(sin_val);
  end

  // ---- stage 3: combine ------------------------------------------------------
  // Map to vehicle rotates by minus the heading, vehicle to map by plus.
  logic                    op3;
  logic signed [SUM_W-1:0] sum_x, sum_y;

  always_ff @(posedge clk) begin
    op3 <= op2;
    if (op2 == OP_MAP_TO_VEHICLE) begin
      sum_x <= SUM_W'(p_ac) + SUM_W'(p_bs);
      sum_y <= SUM_W'(p_bc) - SUM_W'(p_as);
    end else begin
      sum_x <= SUM_W'(p_ac) - SUM_W'(p_bs);
      sum_y <= SUM_W'(p_bc) + SUM_W'(p_as);
    end
  end

  // ---- stage 4: round, add pose, saturate -----------------------------------
  logic signed [RND_W-1:0] rnd_x, rnd_y;
  logic signed [FIN_W-1:0] fin_x, fin_y;
  logic                    clip_x, clip_y;

  always_comb begin
    rnd_x = (RND_W'(sum_x) + HALF) >>> T_SHIFT;
    rnd_y = (RND_W'(sum_y) + HALF) >>> T_SHIFT;
    fin_x = FIN_W'(rnd_x) + ((op3 == OP_VEHICLE_TO_MAP) ? FIN_W'(pose_x) : FIN_W'(0));
    fin_y = FIN_W'(rnd_y) + ((op3 == OP_VEHICLE_TO_MAP) ? FIN_W'(pose_y) : FIN_W'(0));
    clip_x = (fin_x > SAT_MAX) || (fin_x < SAT_MIN);
    clip_y = (fin_y > SAT_MAX) || (fin_y < SAT_MIN);
  end

  always_ff @(posedge clk) begin
    out_x     <= (fin_x > SAT_MAX) ? COORD_W'(SAT_MAX) :
                 ((fin_x < SAT_MIN) ? COORD_W'(SAT_MIN) : COORD_W'(fin_x));
    out_y     <= (fin_y > SAT_MAX) ? COORD_W'(SAT_MAX) :
                 ((fin_y < SAT_MIN) ? COORD_W'(SAT_MIN) : COORD_W'(fin_y));
    saturated <= clip_x || clip_y;
  end

  // ---- checks ----------------------------------------------------------------
  // Every result traces back to an accepted item carried through v1, v2 and v3.
  assert property (@(posedge clk) disable iff (rst) done |-> $past(accept, 4))
    else $error("result strobe without a matching accepted item");

  // A heading write must lock out items until the new trig values are in.
  assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && (cfg_index == REG_HEADING)) |=> busy)
    else $error("heading write did not hold off new items");

  // A clipped result sits at one of the range limits.
  assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |->
      (out_x == COORD_W'(SAT_MAX)) || (out_x == COORD_W'(SAT_MIN)) ||
      (out_y == COORD_W'(SAT_MAX)) || (out_y == COORD_W'(SAT_MIN)))
    else $error("saturated flag set on an unclipped result");

endmodule

>>> dv/planar_frame_transform_top_tb.sv
`timescale 1ns / 1ps
module planar_frame_transform_top_tb;
  import pft_pkg::*;

  // Trig values are Q2.16: 1.0 is 2^16
  localparam int TRIG_FRAC = TRIG_BITS_DEF - 2;
  localparam longint TRIG_UNIT = longint'(1) <<< TRIG_FRAC;

  // Index past the last register; writes to it must leave the pose alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

  localparam logic [HEADING_W-1:0] ANGLE_QUARTER = 16'h4000;
  localparam logic [HEADING_W-1:0] ANGLE_HALF    = 16'h8000;
  localparam logic [HEADING_W-1:0] ANGLE_3QUART  = 16'hC000;
  localparam logic [HEADING_W-1:0] ANGLE_EIGHTH  = 16'h2000;
  localparam logic [HEADING_W-1:0] ANGLE_TOP     = 16'hFFFF;

  // Let the pipeline drain with a margin before touching registers
  localparam int DRAIN_CYCLES = 12;
  localparam int SETTLE_LIMIT = 200;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      clip;
  } frame_point_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       operation;
  logic signed [COORD_W-1:0]  point_x;
  logic signed [COORD_W-1:0]  point_y;
  logic                       done;
  logic signed [COORD_W-1:0]  out_x;
  logic signed [COORD_W-1:0]  out_y;
  logic                       saturated;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COORD_W-1:0]         cfg_data;

  // Shadow copy of the pose and of the trig values the block should hold
  longint               pose_x_map;
  longint               pose_y_map;
  logic [HEADING_W-1:0] heading_angle;
  longint               heading_cos;
  longint               heading_sin;

  // arctan(2^-i) at 2^32 units per turn
  longint atan_units [CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  frame_point_t expected_points[$];
  frame_point_t head_point;

  int errors;
  int max_gap;
  int items_to_vehicle;
  int items_to_map;
  int clipped_points;
  int heading_writes;
  int results_seen;

  planar_frame_transform_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .point_x   (point_x),
    .point_y   (point_y),
    .done      (done),
    .out_x     (out_x),
    .out_y     (out_y),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Round half up: add half an LSB, then floor-shift
  function automatic longint round_q(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_unit(input longint v);
    if (v > TRIG_UNIT) return TRIG_UNIT;
    if (v < -TRIG_UNIT) return -TRIG_UNIT;
    return v;
  endfunction

  // Form cosine and sine of the heading: CORDIC over the first quadrant,
  // then fold in the quadrant exactly from the top two angle bits.
  function automatic void rotate_heading(input logic [HEADING_W-1:0] angle);
    longint zr, xr, yr, step_x, step_y, c, s;
    zr = longint'(angle[13:0]) <<< 16;
    xr = 652032874;
    yr = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      step_x = yr >>> i;
      step_y = xr >>> i;
      if (zr >= 0) begin
        xr = xr - step_x;
        yr = yr + step_y;
        zr = zr - atan_units[i];
      end else begin
        xr = xr + step_x;
        yr = yr - step_y;
        zr = zr + atan_units[i];
      end
    end
    c = clamp_unit(round_q(xr, CORDIC_FRAC - TRIG_FRAC));
    s = clamp_unit(round_q(yr, CORDIC_FRAC - TRIG_FRAC));
    case (angle[15:14])
      2'd0: begin
        heading_cos = c;
        heading_sin = s;
      end
      2'd1: begin
        heading_cos = -s;
        heading_sin = c;
      end
      2'd2: begin
        heading_cos = -c;
        heading_sin = -s;
      end
      default: begin
        heading_cos = s;
        heading_sin = -c;
      end
    endcase
  endfunction

  function automatic frame_point_t transform_point(input logic op,
                                                  input logic signed [COORD_W-1:0] px,
                                                  input logic signed [COORD_W-1:0] py);
    longint dx, dy, rx, ry;
    frame_point_t r;
    if (op == OP_MAP_TO_VEHICLE) begin
      // Difference is kept wide, so it never wraps before the rotation
      dx = longint'(px) - pose_x_map;
      dy = longint'(py) - pose_y_map;
      rx = round_q(dx * heading_cos + dy * heading_sin, TRIG_FRAC);
      ry = round_q(dy * heading_cos - dx * heading_sin, TRIG_FRAC);
    end else begin
      dx = longint'(px);
      dy = longint'(py);
      rx = round_q(dx * heading_cos - dy * heading_sin, TRIG_FRAC) + pose_x_map;
      ry = round_q(dy * heading_cos + dx * heading_sin, TRIG_FRAC) + pose_y_map;
    end
    r.clip = (rx > COORD_MAX) || (rx < COORD_MIN) || (ry > COORD_MAX) || (ry < COORD_MIN);
    r.x = (rx > COORD_MAX) ? COORD_MAX : (rx < COORD_MIN) ? COORD_MIN : rx[COORD_W-1:0];
    r.y = (ry > COORD_MAX) ? COORD_MAX : (ry < COORD_MIN) ? COORD_MIN : ry[COORD_W-1:0];
    return r;
  endfunction

  // Mostly fully random words, with the extremes and small coordinates mixed in
  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3, 4: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      default: return $urandom();
    endcase
  endfunction

  // Send one item: idle for a drawn number of cycles, hold start until
  // accepted, then record the point the block should return.
  task automatic send_point(input logic op,
                            input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py);
    int gap;
    frame_point_t want;
    gap = $urandom_range(0, max_gap);
    cfg_valid = 1'b0;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    operation = op;
    point_x = px;
    point_y = py;
    do @(posedge clk); while (busy);
    want = transform_point(op, px, py);
    expected_points.push_back(want);
    if (op == OP_MAP_TO_VEHICLE) items_to_vehicle++;
    else items_to_map++;
    if (want.clip) clipped_points++;
    @(negedge clk);
  endtask

  // Write one register; update the shadow state at the accepting edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    repeat ($urandom_range(0, max_gap)) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_POSE_X: pose_x_map = longint'($signed(data));
      REG_POSE_Y: pose_y_map = longint'($signed(data));
      REG_HEADING: begin
        heading_angle = data[HEADING_W-1:0];
        rotate_heading(heading_angle);
        heading_writes++;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Heading write with junk in the unused upper bits
  task automatic write_heading(input logic [HEADING_W-1:0] angle);
    write_reg(REG_HEADING, {16'($urandom()), angle});
  endtask

  // Drop start and wait for every outstanding point, then let the pipeline empty
  task automatic settle();
    int waited;
    start = 1'b0;
    waited = 0;
    while (expected_points.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_points.size() != 0) begin
      $display("%0t: %0d expected points never returned", $time, expected_points.size());
      errors += expected_points.size();
      expected_points.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Identity pose straight out of reset: extremes pass through unchanged
  task automatic test_reset_pose();
    send_point(OP_MAP_TO_VEHICLE, 32'sd0, 32'sd0);
    send_point(OP_VEHICLE_TO_MAP, COORD_MAX, COORD_MAX);
    send_point(OP_MAP_TO_VEHICLE, COORD_MIN, COORD_MIN);
    send_point(OP_VEHICLE_TO_MAP, COORD_MIN, COORD_MAX);
    send_point(OP_MAP_TO_VEHICLE, 32'sd1234, -32'sd5678);
    settle();
  endtask

  // Point minus pose spans 33 bits; only the outputs may clip
  task automatic test_large_difference();
    write_reg(REG_POSE_X, COORD_MAX);
    write_reg(REG_POSE_Y, COORD_MIN);
    send_point(OP_MAP_TO_VEHICLE, COORD_MIN, COORD_MAX);
    send_point(OP_VEHICLE_TO_MAP, COORD_MAX, COORD_MIN);
    settle();
    write_heading(ANGLE_HALF);
    send_point(OP_MAP_TO_VEHICLE, COORD_MIN, COORD_MAX);
    settle();
    // A write past the last register must change nothing
    write_reg(REG_SPARE, $urandom());
    send_point(OP_VEHICLE_TO_MAP, 32'sd40960, -32'sd20480);
    settle();
  endtask

  // Pose writes after a heading write must keep the trig values
  task automatic test_pose_keeps_trig();
    write_heading(ANGLE_EIGHTH);
    write_reg(REG_POSE_X, 32'sd5120);
    write_reg(REG_POSE_Y, -32'sd3072);
    send_point(OP_MAP_TO_VEHICLE, COORD_MAX, COORD_MAX);
    send_point(OP_VEHICLE_TO_MAP, 32'sd300000, -32'sd150000);
    settle();
  endtask

  // Each quadrant boundary and the top of the angle range
  task automatic test_heading_quadrants();
    logic [HEADING_W-1:0] angles [6];
    angles = '{16'h0000, 16'h3FFF, ANGLE_QUARTER, ANGLE_HALF, ANGLE_3QUART, ANGLE_TOP};
    foreach (angles[k]) begin
      write_heading(angles[k]);
      send_point(OP_MAP_TO_VEHICLE, 32'sd300000, -32'sd150000);
      send_point(OP_VEHICLE_TO_MAP, -32'sd2000000, 32'sd777777);
      settle();
    end
  endtask

  // Random poses and streams; every third phase runs with no idling at all
  task automatic test_random_streams();
    int first;
    logic [HEADING_W-1:0] angle;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      max_gap = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 6 : 2;
      first = phase % 3;
      for (int k = 0; k < 3; k++) begin
        case ((first + k) % 3)
          0: write_reg(REG_POSE_X, pick_coord());
          1: write_reg(REG_POSE_Y, pick_coord());
          default: begin
            case ($urandom_range(0, 5))
              0: angle = '0;
              1: angle = ANGLE_TOP;
              2: angle = ANGLE_QUARTER;
              default: angle = 16'($urandom());
            endcase
            write_heading(angle);
          end
        endcase
      end
      if (phase % 2 == 1) write_reg(REG_SPARE, $urandom());
      repeat (PHASE_ITEMS) send_point(1'($urandom()), pick_coord(), pick_coord());
    end
    settle();
  endtask

  // Compare each returned point with the oldest one still owed
  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d saturated=%0b",
                 $time, out_x, out_y, saturated);
        errors++;
      end else begin
        head_point = expected_points.pop_front();
        if (out_x !== head_point.x) begin
          $display("%0t: out_x expected %0d actual %0d", $time, head_point.x, out_x);
          errors++;
        end
        if (out_y !== head_point.y) begin
          $display("%0t: out_y expected %0d actual %0d", $time, head_point.y, out_y);
          errors++;
        end
        if (saturated !== head_point.clip) begin
          $display("%0t: saturated expected %0b actual %0b", $time, head_point.clip, saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    operation = OP_MAP_TO_VEHICLE;
    point_x = '0;
    point_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_POSE_X;
    cfg_data = '0;
    errors = 0;
    max_gap = 6;
    items_to_vehicle = 0;
    items_to_map = 0;
    clipped_points = 0;
    heading_writes = 0;
    results_seen = 0;
    // Reset state: zero pose, zero heading, cosine 1.0
    pose_x_map = 0;
    pose_y_map = 0;
    heading_angle = '0;
    heading_cos = TRIG_UNIT;
    heading_sin = 0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_reset_pose();
    test_large_difference();
    test_pose_keeps_trig();
    test_heading_quadrants();
    test_random_streams();

    $display("Transformed %0d points to vehicle frame and %0d to map frame, %0d clipped,",
             items_to_vehicle, items_to_map, clipped_points);
    $display("over %0d heading settings; %0d results checked.", heading_writes, results_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Hold-off well beyond the slowest correct run
  initial begin
    #2000000;
    $display("%0t: run timed out", $time);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
